// ===== hw/rtl/phd_pkg.sv =====
`default_nettype none
package phd_pkg;

  // Decay table geometry
  localparam int unsigned TAIL_DEPTH  = 128;
  localparam int unsigned TAB_AW      = $clog2(TAIL_DEPTH);
  localparam int unsigned DECAY_W     = 8;

  // Field widths
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned VEL_W       = 7;

  // Microseconds to 1024 us slots
  localparam int unsigned MS_SHIFT    = 10;
  localparam int unsigned MS_W        = TIME_W - MS_SHIFT;

  // Scaled threshold terms: decay * peak >> FRAC_SHIFT
  localparam int unsigned FRAC_SHIFT  = 7;
  localparam int unsigned PROD_W      = DECAY_W + SAMPLE_BITS;
  localparam int unsigned ADD_W       = PROD_W - FRAC_SHIFT;
  localparam int unsigned THR_W       = ADD_W + 2;

  localparam logic [VEL_W-1:0] VEL_MAX = VEL_W'(127);

  // Configuration registers
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned BASE_W      = 10;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned SHIFT_W     = 4;
  localparam int unsigned TAIL_W      = 8;

  localparam logic [2:0] REG_BASE_THR = 3'd0;
  localparam logic [2:0] REG_WINDOW   = 3'd1;
  localparam logic [2:0] REG_VSHIFT   = 3'd2;
  localparam logic [2:0] REG_TAIL     = 3'd3;
  localparam logic [2:0] REG_NOTE     = 3'd4;

  localparam logic [BASE_W-1:0]  BASE_THR_RST = BASE_W'(673);
  localparam logic [WIN_W-1:0]   WINDOW_RST   = WIN_W'(1000);
  localparam logic [SHIFT_W-1:0] VSHIFT_RST   = SHIFT_W'(3);
  localparam logic [TAIL_W-1:0]  TAIL_RST     = TAIL_W'(128);
  localparam logic [NOTE_W-1:0]  NOTE_RST     = NOTE_W'(36);

  // Result queue
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_AW      = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CW      = OUT_AW + 1;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TABLE  = 1'b1
  } func_e;

  typedef enum logic {
    EV_NOTE_ON  = 1'b0,
    EV_NOTE_OFF = 1'b1
  } event_kind_e;

  typedef struct packed {
    func_e                  func;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_W-1:0]      now_us;
    logic [IDX_W-1:0]       table_index;
    logic [DECAY_W-1:0]     table_value;
  } in_item_t;

  typedef struct packed {
    event_kind_e       event_kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              last;
  } result_t;

  function automatic logic [VEL_W-1:0] velocity_of(input logic [SAMPLE_BITS-1:0] peak,
                                                    input logic [SHIFT_W-1:0] shift);
    logic [SAMPLE_BITS:0] v;
    v = {1'b0, peak >> shift} + (SAMPLE_BITS+1)'(1);
    if (v > (SAMPLE_BITS+1)'(VEL_MAX)) begin
      return VEL_MAX;
    end
    return v[VEL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/phd_in_if.sv =====
`default_nettype none
interface phd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [phd_pkg::SAMPLE_BITS-1:0] sample_value;
  logic [phd_pkg::TIME_W-1:0]      now_us;
  logic [phd_pkg::IDX_W-1:0]       table_index;
  logic [phd_pkg::DECAY_W-1:0]     table_value;

  modport source (
    output valid, func, sample_value, now_us, table_index, table_value,
    input  ready
  );
  modport sink (
    input  valid, func, sample_value, now_us, table_index, table_value,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/phd_out_if.sv =====
`default_nettype none
interface phd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic [phd_pkg::NOTE_W-1:0] note;
  logic [phd_pkg::VEL_W-1:0]  velocity;
  logic                       last;

  modport source (
    output valid, event_kind, note, velocity, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, note, velocity, last,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/phd_ram.sv =====
`default_nettype none
// Simple RAM: one write port, two registered read ports sharing a read enable.
module phd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/piezo_hit_detector_core.sv =====
`default_nettype none
// Hit detector for one piezo drum pad, with a decaying retrigger mask.
// in_i carries one item per ADC tick (func = sample) or a decay table write
// (func = table). Table writes produce nothing; a sample produces zero, one
// or two results on out_o (note-off before note-on when both occur; the
// last flag marks the final result of the item). Handshake is valid/ready.
// Registers sit behind an APB-style port, 4 bytes apart, pready always high.
// An item passes through the input stage (where the decay table is
// addressed) and then the evaluate stage (table data arrives, the
// threshold is formed and the state updated), then its results enter a
// 4-entry result queue. Throughput is one item per cycle while the
// evaluate stage can advance; the result queue drains one result per
// cycle, so a run of items that produce two results backs up the queue.
// The evaluate stage advances whenever the queue holds at most two results,
// so in_i.ready never waits on out_o.ready combinationally.
// Reset clears the pipeline, the queue, the hit state and the registers to
// their defaults. The decay table is not cleared; it must be loaded before
// a hit can age past its listen window.
// A stalled receiver fills the queue, then holds both stages and in_i.ready.
module piezo_hit_detector_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  phd_in_if.sink                       in_i,
  phd_out_if.source                    out_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [phd_pkg::APB_AW-1:0]   paddr,
  input  wire  [phd_pkg::APB_DW-1:0]   pwdata,
  output logic [phd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [phd_pkg::BASE_W-1:0]  base_thr_q;
  logic [phd_pkg::WIN_W-1:0]   window_q;
  logic [phd_pkg::SHIFT_W-1:0] vshift_q;
  logic [phd_pkg::TAIL_W-1:0]  tail_q;
  logic [phd_pkg::NOTE_W-1:0]  note_q;
  logic [2:0]                  reg_idx;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[phd_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_thr_q <= phd_pkg::BASE_THR_RST;
      window_q   <= phd_pkg::WINDOW_RST;
      vshift_q   <= phd_pkg::VSHIFT_RST;
      tail_q     <= phd_pkg::TAIL_RST;
      note_q     <= phd_pkg::NOTE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        phd_pkg::REG_BASE_THR: base_thr_q <= pwdata[phd_pkg::BASE_W-1:0];
        phd_pkg::REG_WINDOW:   window_q   <= pwdata[phd_pkg::WIN_W-1:0];
        phd_pkg::REG_VSHIFT:   vshift_q   <= pwdata[phd_pkg::SHIFT_W-1:0];
        phd_pkg::REG_TAIL:     tail_q     <= pwdata[phd_pkg::TAIL_W-1:0];
        phd_pkg::REG_NOTE:     note_q     <= pwdata[phd_pkg::NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      phd_pkg::REG_BASE_THR: prdata = phd_pkg::APB_DW'(base_thr_q);
      phd_pkg::REG_WINDOW:   prdata = phd_pkg::APB_DW'(window_q);
      phd_pkg::REG_VSHIFT:   prdata = phd_pkg::APB_DW'(vshift_q);
      phd_pkg::REG_TAIL:     prdata = phd_pkg::APB_DW'(tail_q);
      phd_pkg::REG_NOTE:     prdata = phd_pkg::APB_DW'(note_q);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  phd_pkg::in_item_t          s1_q, s2_q, in_item;
  logic                       s1_valid_q, s2_valid_q;
  logic [phd_pkg::OUT_CW-1:0] cnt_q, cnt_d;
  logic                       adv, in_fire, s2_fire, out_pop;

  // Evaluate stage may retire when the queue has room for two results.
  assign adv         = !s2_valid_q || (cnt_q <= phd_pkg::OUT_CW'(phd_pkg::OUT_DEPTH - 2));
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s2_fire     = s2_valid_q && adv && (s2_q.func == phd_pkg::FUNC_SAMPLE);

  always_comb begin
    in_item.func         = phd_pkg::func_e'(in_i.func);
    in_item.sample_value = in_i.sample_value;
    in_item.now_us       = in_i.now_us;
    in_item.table_index  = in_i.table_index;
    in_item.table_value  = in_i.table_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item;
    end
    if (adv) begin
      s2_q <= s1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Hit state
  // ---------------------------------------------------------------------
  logic                            listening_q, hit_recent_q, prev_recent_q;
  logic [phd_pkg::SAMPLE_BITS-1:0] peak_q, prev_peak_q;
  logic [phd_pkg::TIME_W-1:0]      peak_time_q, ws_q, prev_time_q;

  // ---------------------------------------------------------------------
  // Decay table lookup (input stage)
  // The evaluate stage may still move peak_time and prev_time, so the
  // input stage reads every slot they can end up at:
  //   peak slot: from peak_time now, or from the evaluating item's time
  //   prev slot: from prev_time now, or from peak_time now (copied on retrigger)
  // The evaluate stage picks one with flags registered alongside the reads.
  // ---------------------------------------------------------------------
  logic [phd_pkg::TIME_W-1:0]  us_a, us_b, us_c;
  logic [phd_pkg::MS_W-1:0]    ms_a, ms_b, ms_c;
  logic                        inr_a_q, inr_b_q, inr_c_q;
  logic [phd_pkg::DECAY_W-1:0] pk_a_rd, pk_b_rd, pv_c_rd, pv_a_rd;
  logic                        tab_we;
  logic                        pk_new_q, pv_shift_q;
  logic                        pk_new_d, pv_shift_d;

  assign us_a = s1_q.now_us - peak_time_q;
  assign us_b = s1_q.now_us - s2_q.now_us;
  assign us_c = s1_q.now_us - prev_time_q;
  assign ms_a = us_a[phd_pkg::TIME_W-1:phd_pkg::MS_SHIFT];
  assign ms_b = us_b[phd_pkg::TIME_W-1:phd_pkg::MS_SHIFT];
  assign ms_c = us_c[phd_pkg::TIME_W-1:phd_pkg::MS_SHIFT];

  // Table write commits as the item leaves the input stage, ahead of any
  // later item's read.
  assign tab_we = adv && s1_valid_q && (s1_q.func == phd_pkg::FUNC_TABLE) &&
                  (phd_pkg::IDX_W'(s1_q.table_index) < phd_pkg::IDX_W'(phd_pkg::TAIL_DEPTH - 1)
                   || s1_q.table_index == phd_pkg::IDX_W'(phd_pkg::TAIL_DEPTH - 1));

  phd_ram #(
    .WIDTH (phd_pkg::DECAY_W),
    .DEPTH (phd_pkg::TAIL_DEPTH)
  ) u_tab_peak (
    .clk_i     (clk_i),
    .we_i      (tab_we),
    .waddr_i   (s1_q.table_index[phd_pkg::TAB_AW-1:0]),
    .wdata_i   (s1_q.table_value),
    .re_i      (adv),
    .raddr_a_i (ms_a[phd_pkg::TAB_AW-1:0]),
    .raddr_b_i (ms_b[phd_pkg::TAB_AW-1:0]),
    .rdata_a_o (pk_a_rd),
    .rdata_b_o (pk_b_rd)
  );

  phd_ram #(
    .WIDTH (phd_pkg::DECAY_W),
    .DEPTH (phd_pkg::TAIL_DEPTH)
  ) u_tab_prev (
    .clk_i     (clk_i),
    .we_i      (tab_we),
    .waddr_i   (s1_q.table_index[phd_pkg::TAB_AW-1:0]),
    .wdata_i   (s1_q.table_value),
    .re_i      (adv),
    .raddr_a_i (ms_c[phd_pkg::TAB_AW-1:0]),
    .raddr_b_i (ms_a[phd_pkg::TAB_AW-1:0]),
    .rdata_a_o (pv_c_rd),
    .rdata_b_o (pv_a_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inr_a_q    <= 1'b0;
      inr_b_q    <= 1'b0;
      inr_c_q    <= 1'b0;
      pk_new_q   <= 1'b0;
      pv_shift_q <= 1'b0;
    end else if (adv) begin
      inr_a_q    <= ms_a < phd_pkg::MS_W'(phd_pkg::TAIL_DEPTH);
      inr_b_q    <= ms_b < phd_pkg::MS_W'(phd_pkg::TAIL_DEPTH);
      inr_c_q    <= ms_c < phd_pkg::MS_W'(phd_pkg::TAIL_DEPTH);
      pk_new_q   <= pk_new_d;
      pv_shift_q <= pv_shift_d;
    end
  end

  // ---------------------------------------------------------------------
  // Evaluate stage
  // ---------------------------------------------------------------------
  logic [phd_pkg::DECAY_W-1:0]     t_pk, t_pv;
  logic [phd_pkg::TIME_W-1:0]      us, us_p, wend_diff;
  logic [phd_pkg::MS_W-1:0]        ms, ms_p;
  logic [phd_pkg::PROD_W-1:0]      prod_pk, prod_pv;
  logic [phd_pkg::ADD_W-1:0]       add_pk, add_pv;
  logic [phd_pkg::THR_W-1:0]       thr;
  logic [phd_pkg::SAMPLE_BITS-1:0] value, peak_cur, peak_fin;
  logic                            expire, expire_p, in_win, checks, expire_ev;
  logic                            hit_mid, prev_mid, start, copy, active, upd, win_end;

  always_comb begin
    if (pk_new_q) begin
      t_pk = inr_b_q ? pk_b_rd : '0;
    end else begin
      t_pk = inr_a_q ? pk_a_rd : '0;
    end
    if (pv_shift_q) begin
      t_pv = inr_a_q ? pv_a_rd : '0;
    end else begin
      t_pv = inr_c_q ? pv_c_rd : '0;
    end
  end

  assign value    = s2_q.sample_value;
  assign us       = s2_q.now_us - peak_time_q;
  assign us_p     = s2_q.now_us - prev_time_q;
  assign ms       = us[phd_pkg::TIME_W-1:phd_pkg::MS_SHIFT];
  assign ms_p     = us_p[phd_pkg::TIME_W-1:phd_pkg::MS_SHIFT];
  assign expire   = ms >= phd_pkg::MS_W'(tail_q);
  assign expire_p = ms_p >= phd_pkg::MS_W'(tail_q);
  assign in_win   = us < phd_pkg::TIME_W'(window_q);

  assign prod_pk  = phd_pkg::PROD_W'(t_pk) * phd_pkg::PROD_W'(peak_q);
  assign prod_pv  = phd_pkg::PROD_W'(t_pv) * phd_pkg::PROD_W'(prev_peak_q);
  assign add_pk   = in_win ? phd_pkg::ADD_W'(peak_q)
                           : prod_pk[phd_pkg::PROD_W-1:phd_pkg::FRAC_SHIFT];
  assign add_pv   = prod_pv[phd_pkg::PROD_W-1:phd_pkg::FRAC_SHIFT];

  // Recent hit still masking: raise the threshold by its own term and by a
  // still-ringing earlier hit.
  assign checks    = !listening_q && hit_recent_q && !expire;
  assign expire_ev = !listening_q && hit_recent_q && expire;

  assign thr = phd_pkg::THR_W'(base_thr_q)
             + (checks ? phd_pkg::THR_W'(add_pk) : '0)
             + ((checks && prev_recent_q && !expire_p) ? phd_pkg::THR_W'(add_pv) : '0);

  assign hit_mid  = hit_recent_q && !expire_ev;
  assign prev_mid = prev_recent_q && !(checks && expire_p);
  assign start    = !listening_q && (phd_pkg::THR_W'(value) >= thr);
  assign copy     = start && hit_mid;
  assign active   = listening_q || start;
  assign peak_cur = start ? '0 : peak_q;
  assign upd      = active && (value > peak_cur);
  assign peak_fin = upd ? value : peak_cur;

  // Window end, wrapping compare. A window opened by this very item ends at
  // once only when its length is zero.
  assign wend_diff = s2_q.now_us - ws_q - phd_pkg::TIME_W'(window_q);
  assign win_end   = active && (start ? (window_q == '0)
                                      : !wend_diff[phd_pkg::TIME_W-1]);

  assign pk_new_d   = s2_fire && upd;
  assign pv_shift_d = s2_fire && copy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listening_q   <= 1'b0;
      hit_recent_q  <= 1'b0;
      prev_recent_q <= 1'b0;
      peak_q        <= '0;
      peak_time_q   <= '0;
      ws_q          <= '0;
      prev_peak_q   <= '0;
      prev_time_q   <= '0;
    end else if (s2_fire) begin
      listening_q   <= active && !win_end;
      hit_recent_q  <= win_end || hit_mid;
      prev_recent_q <= copy || prev_mid;
      peak_q        <= peak_fin;
      if (upd) begin
        peak_time_q <= s2_q.now_us;
      end
      if (start) begin
        ws_q <= s2_q.now_us;
      end
      if (copy) begin
        prev_peak_q <= peak_q;
        prev_time_q <= peak_time_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  phd_pkg::result_t           q_mem [phd_pkg::OUT_DEPTH];
  phd_pkg::result_t           res_off, res_on, head;
  logic [phd_pkg::OUT_AW-1:0] wp_q, rp_q, wp_on;
  logic                       push_off, push_on;

  assign push_off = s2_fire && expire_ev;
  assign push_on  = s2_fire && win_end;
  assign wp_on    = push_off ? wp_q + phd_pkg::OUT_AW'(1) : wp_q;
  assign out_pop  = out_o.valid && out_o.ready;

  always_comb begin
    res_off.event_kind = phd_pkg::EV_NOTE_OFF;
    res_off.note       = note_q;
    res_off.velocity   = phd_pkg::velocity_of(peak_q, vshift_q);
    res_off.last       = !win_end;
    res_on.event_kind  = phd_pkg::EV_NOTE_ON;
    res_on.note        = note_q;
    res_on.velocity    = phd_pkg::velocity_of(peak_fin, vshift_q);
    res_on.last        = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_off) begin
      q_mem[wp_q] <= res_off;
    end
    if (push_on) begin
      q_mem[wp_on] <= res_on;
    end
  end

  assign cnt_d = cnt_q + phd_pkg::OUT_CW'(push_off) + phd_pkg::OUT_CW'(push_on)
               - phd_pkg::OUT_CW'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + phd_pkg::OUT_AW'(push_off) + phd_pkg::OUT_AW'(push_on);
      rp_q  <= rp_q + phd_pkg::OUT_AW'(out_pop);
      cnt_q <= cnt_d;
    end
  end

  assign head             = q_mem[rp_q];
  assign out_o.valid      = cnt_q != '0;
  assign out_o.event_kind = head.event_kind;
  assign out_o.note       = head.note;
  assign out_o.velocity   = head.velocity;
  assign out_o.last       = head.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= phd_pkg::OUT_CW'(phd_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |-> cnt_q <= phd_pkg::OUT_CW'(phd_pkg::OUT_DEPTH - 2))
    else $error("evaluate stage retired without queue room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && win_end) |=> (hit_recent_q && !listening_q))
    else $error("note-on did not arm the retrigger mask");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_shift_q |-> prev_recent_q)
    else $error("prev slot selected without a ringing earlier hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    listening_q |-> !hit_recent_q || $stable(hit_recent_q) || $rose(listening_q))
    else $error("hit state changed inside a listen window");

endmodule
`default_nettype wire
